>>> hw/rtl/sid_pkg.sv
// Package for the signed integer to decimal ASCII converter.
// Holds the microcode word types, the program table and character constants.
// No dependencies.
package sid_pkg;

    localparam int STEP_W = 3;

    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_MINUS = 8'd45;

    typedef enum logic [2:0] {
        OP_IDLE   = 3'd0,
        OP_DABBLE = 3'd1,
        OP_SIGN   = 3'd2,
        OP_STRIP  = 3'd3,
        OP_EMIT   = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        COND_NONE   = 3'd0,
        COND_WAIT   = 3'd1,
        COND_BITS   = 3'd2,
        COND_STRIP  = 3'd3,
        COND_DIGITS = 3'd4
    } t_cond;

    typedef struct packed {
        t_op               op;
        t_cond             cond;
        logic [STEP_W-1:0] next;
    } t_word;

    typedef struct packed {
        logic start;
        logic bits_more;
        logic strip_more;
        logic digits_more;
    } t_flags;

    localparam logic [STEP_W-1:0] STEP_IDLE   = 3'd0;
    localparam logic [STEP_W-1:0] STEP_DABBLE = 3'd1;
    localparam logic [STEP_W-1:0] STEP_SIGN   = 3'd2;
    localparam logic [STEP_W-1:0] STEP_STRIP  = 3'd3;
    localparam logic [STEP_W-1:0] STEP_EMIT   = 3'd4;

    function automatic t_word sid_rom(input logic [STEP_W-1:0] step);
        t_word w;
        case (step)
            STEP_IDLE:   w = '{op: OP_IDLE,   cond: COND_WAIT,   next: STEP_DABBLE};
            STEP_DABBLE: w = '{op: OP_DABBLE, cond: COND_BITS,   next: STEP_SIGN};
            STEP_SIGN:   w = '{op: OP_SIGN,   cond: COND_NONE,   next: STEP_STRIP};
            STEP_STRIP:  w = '{op: OP_STRIP,  cond: COND_STRIP,  next: STEP_EMIT};
            STEP_EMIT:   w = '{op: OP_EMIT,   cond: COND_DIGITS, next: STEP_IDLE};
            default:     w = '{op: OP_IDLE,   cond: COND_NONE,   next: STEP_IDLE};
        endcase
        return w;
    endfunction

endpackage

>>> hw/rtl/sid_seq.sv
// Microcode sequencer: step counter, program table lookup and loop conditions.
// Depends on sid_pkg.
module sid_seq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  sid_pkg::t_flags i_flags,
    output sid_pkg::t_word  o_word
);

    logic [sid_pkg::STEP_W-1:0] r_step;
    logic [sid_pkg::STEP_W-1:0] n_step;
    sid_pkg::t_word             w;
    logic                       stay;

    always_comb begin
        w = sid_pkg::sid_rom(r_step);
        case (w.cond)
            sid_pkg::COND_NONE:   stay = 1'b0;
            sid_pkg::COND_WAIT:   stay = !i_flags.start;
            sid_pkg::COND_BITS:   stay = i_flags.bits_more;
            sid_pkg::COND_STRIP:  stay = i_flags.strip_more;
            sid_pkg::COND_DIGITS: stay = i_flags.digits_more;
            default:              stay = 1'b0;
        endcase
        n_step = stay ? r_step : w.next;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= sid_pkg::STEP_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_word = w;

endmodule

>>> hw/rtl/sid_dp.sv
// Datapath: magnitude shift register, bit-serial double dabble BCD register,
// digit counter and registered character output. Depends on sid_pkg.
module sid_dp #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  sid_pkg::t_word         i_word,
    input  logic                   i_start,
    input  logic [VALUE_WIDTH-1:0] i_value,
    output sid_pkg::t_flags        o_flags,
    output logic                   o_valid,
    output logic [7:0]             o_text_char,
    output logic                   o_last
);

    localparam int ND     = (((VALUE_WIDTH - 1) * 1233) >> 12) + 1;
    localparam int BCD_W  = 4 * ND;
    localparam int BITS_W = $clog2(VALUE_WIDTH + 1);
    localparam int DCNT_W = $clog2(ND + 1);

    logic [VALUE_WIDTH-1:0] r_mag,   n_mag;
    logic [BCD_W-1:0]       r_bcd,   n_bcd;
    logic [BITS_W-1:0]      r_bits,  n_bits;
    logic [DCNT_W-1:0]      r_dcnt,  n_dcnt;
    logic                   r_neg,   n_neg;
    logic                   r_valid, n_valid;
    logic [7:0]             r_char,  n_char;
    logic                   r_last,  n_last;

    logic [BCD_W-1:0] adj;
    logic [3:0]       top;
    logic             digits_more;
    logic             strip_more;

    always_comb begin
        for (int d = 0; d < ND; d++) begin
            if (r_bcd[4*d +: 4] >= 4'd5) begin
                adj[4*d +: 4] = r_bcd[4*d +: 4] + 4'd3;
            end else begin
                adj[4*d +: 4] = r_bcd[4*d +: 4];
            end
        end
    end

    assign top         = r_bcd[BCD_W-1 -: 4];
    assign digits_more = (r_dcnt > DCNT_W'(1));
    assign strip_more  = digits_more && (top == 4'd0);

    assign o_flags = '{start:       i_start,
                       bits_more:   (r_bits > BITS_W'(1)),
                       strip_more:  strip_more,
                       digits_more: digits_more};

    always_comb begin
        n_mag   = r_mag;
        n_bcd   = r_bcd;
        n_bits  = r_bits;
        n_dcnt  = r_dcnt;
        n_neg   = r_neg;
        n_valid = 1'b0;
        n_char  = r_char;
        n_last  = r_last;
        case (i_word.op)
            sid_pkg::OP_IDLE: begin
                if (i_start) begin
                    n_neg  = i_value[VALUE_WIDTH-1];
                    n_mag  = i_value[VALUE_WIDTH-1] ? (~i_value + VALUE_WIDTH'(1)) : i_value;
                    n_bcd  = '0;
                    n_bits = BITS_W'(VALUE_WIDTH);
                    n_dcnt = DCNT_W'(ND);
                end
            end
            sid_pkg::OP_DABBLE: begin
                n_bcd  = {adj[BCD_W-2:0], r_mag[VALUE_WIDTH-1]};
                n_mag  = {r_mag[VALUE_WIDTH-2:0], 1'b0};
                n_bits = r_bits - BITS_W'(1);
            end
            sid_pkg::OP_SIGN: begin
                if (r_neg) begin
                    n_valid = 1'b1;
                    n_char  = sid_pkg::CHAR_MINUS;
                    n_last  = 1'b0;
                end
            end
            sid_pkg::OP_STRIP: begin
                if (strip_more) begin
                    n_bcd  = {r_bcd[BCD_W-5:0], 4'd0};
                    n_dcnt = r_dcnt - DCNT_W'(1);
                end
            end
            sid_pkg::OP_EMIT: begin
                n_valid = 1'b1;
                n_char  = sid_pkg::CHAR_ZERO + {4'd0, top};
                n_last  = !digits_more;
                n_bcd   = {r_bcd[BCD_W-5:0], 4'd0};
                n_dcnt  = r_dcnt - DCNT_W'(1);
            end
            default: begin
                n_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_mag  <= n_mag;
        r_bcd  <= n_bcd;
        r_bits <= n_bits;
        r_dcnt <= n_dcnt;
        r_neg  <= n_neg;
        r_char <= n_char;
        r_last <= n_last;
    end

    assign o_valid     = r_valid;
    assign o_text_char = r_char;
    assign o_last      = r_last;

endmodule

>>> hw/rtl/signed_int_to_decimal_ascii.sv
// Top level of the signed integer to decimal ASCII converter.
// Instantiates sid_seq and sid_dp; depends on sid_pkg.
//
// channel  ports                          transfer
// -------  -----------------------------  -------------------------------
// input    start, i_value                 edge with start high, busy low
// result   o_valid, o_text_char, o_last   every edge with o_valid high
//
// One value passes through the load step, the double dabble loop over all VALUE_WIDTH bits,
// the sign step, the strip loop that drops each leading zero digit and ends with a final check,
// and the emit loop that puts out the digits, most significant digit first.
// busy rises the cycle after the transfer and is low again when the last character shows.
// Reset returns the step counter to idle and drops any result in flight.
// Results are never stalled; each one is shown for exactly one cycle.
module signed_int_to_decimal_ascii #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    input  logic [VALUE_WIDTH-1:0] i_value,
    output logic                   busy,
    output logic                   o_valid,
    output logic [7:0]             o_text_char,
    output logic                   o_last
);

    sid_pkg::t_word  word;
    sid_pkg::t_flags flags;

    assign busy = (word.op != sid_pkg::OP_IDLE);

    sid_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_word  (word)
    );

    sid_dp #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_word      (word),
        .i_start     (start),
        .i_value     (i_value),
        .o_flags     (flags),
        .o_valid     (o_valid),
        .o_text_char (o_text_char),
        .o_last      (o_last)
    );

endmodule

>>> tb/testbench.sv
// Self-checking testbench for signed_int_to_decimal_ascii: drives signed 32-bit values
// and compares every decimal ASCII character and its last flag against a local predictor.
// Depends on sid_pkg and the signed_int_to_decimal_ascii RTL.
module testbench;

    localparam int QUIET_LIMIT = 2000;
    localparam int TAIL_CYCLES = 60;
    localparam int PHASE_ITEMS = 115;

    typedef struct {
        logic [31:0] value;
        int          idle_pct;
        bit          settle;
    } t_stim;

    typedef struct {
        logic [7:0] ch;
        logic       last;
    } t_char;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic [31:0] i_value = '0;
    logic        busy;
    logic        o_valid;
    logic [7:0]  o_text_char;
    logic        o_last;

    t_stim value_q[$];
    t_char text_q[$];
    t_stim cur;
    t_char want;
    logic  took = 1'b0;
    int    gap = 0;
    int    quiet = 0;
    int    fail_cnt = 0;

    int corner_vals[20] = '{0, 1, -1, 9, -9, 10, -10, 99, 100, -100, 12345, -67890,
                            999999999, 1000000000, -1000000000, 1234567890,
                            2147483647, -2147483647, 32'h8000_0000, 7};

    signed_int_to_decimal_ascii #(
        .VALUE_WIDTH(32)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_value    (i_value),
        .busy       (busy),
        .o_valid    (o_valid),
        .o_text_char(o_text_char),
        .o_last     (o_last)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic void predict_text(input logic [31:0] v);
        logic [31:0] mag;
        logic [7:0]  digs[$];
        t_char       c;
        mag = v[31] ? (~v + 32'd1) : v;
        do begin
            digs.push_front(sid_pkg::CHAR_ZERO + 8'(mag % 32'd10));
            mag = mag / 32'd10;
        end while (mag != 0);
        if (v[31]) begin
            c.ch = sid_pkg::CHAR_MINUS;
            c.last = 1'b0;
            text_q.push_back(c);
        end
        foreach (digs[i]) begin
            c.ch = digs[i];
            c.last = (i == digs.size() - 1);
            text_q.push_back(c);
        end
    endfunction

    function automatic logic [31:0] rand_value();
        longint      span;
        logic [31:0] v;
        span = 1;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = $urandom();
            4, 5, 6: begin
                repeat ($urandom_range(1, 9)) span *= 10;
                v = $urandom_range(0, 32'(span - 1));
            end
            7: begin
                repeat ($urandom_range(0, 9)) span *= 10;
                v = 32'(span) + 32'($urandom_range(0, 2)) - 32'd1;
            end
            8: begin
                if ($urandom_range(0, 1)) v = 32'h8000_0000 + 32'($urandom_range(0, 3));
                else v = 32'h7FFF_FFFF - 32'($urandom_range(0, 3));
            end
            default: v = $urandom_range(0, 20);
        endcase
        if ($urandom_range(0, 1)) v = -v;
        return v;
    endfunction

    function automatic void queue_value(input logic [31:0] v, input int pct, input bit settle);
        t_stim s;
        s.value = v;
        s.idle_pct = pct;
        s.settle = settle;
        value_q.push_back(s);
    endfunction

    // Driver: present the next value on the falling edge, hold it until the transfer.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || took) begin
            if (gap != 0) begin
                gap = gap - 1;
                start <= 1'b0;
            end else if (value_q.size() == 0 || (value_q[0].settle && text_q.size() != 0)) begin
                start <= 1'b0;
            end else if ($urandom_range(0, 99) < value_q[0].idle_pct) begin
                gap = $urandom_range(0, 59);
                start <= 1'b0;
            end else begin
                cur = value_q.pop_front();
                i_value <= cur.value;
                start <= 1'b1;
            end
        end
    end

    // Monitor: record transfers, check characters, run the watchdog.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            took <= 1'b0;
            quiet <= 0;
        end else begin
            took <= start && !busy;
            if (start && !busy) predict_text(i_value);
            if (o_valid) begin
                if (text_q.size() == 0) begin
                    $error("text_char: no character expected, actual %0d", o_text_char);
                    fail_cnt++;
                end else begin
                    want = text_q.pop_front();
                    if (o_text_char !== want.ch) begin
                        $error("text_char: expected %0d, actual %0d", want.ch, o_text_char);
                        fail_cnt++;
                    end
                    if (o_last !== want.last) begin
                        $error("last: expected %0b, actual %0b", want.last, o_last);
                        fail_cnt++;
                    end
                end
            end
            if ((start && !busy) || o_valid) begin
                quiet <= 0;
            end else if (quiet >= QUIET_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end else begin
                quiet <= quiet + 1;
            end
        end
    end

    initial begin
        int pct[4] = '{0, 64, 0, 38};
        foreach (corner_vals[i]) queue_value(corner_vals[i], 0, 1'b0);
        foreach (pct[p]) begin
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                queue_value(rand_value(), pct[p], n == 0 || n == PHASE_ITEMS / 2);
            end
        end
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        do @(negedge i_clk);
        while (!(value_q.size() == 0 && (!start || took) && text_q.size() == 0));
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_cnt == 0 && text_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
